// File: src/assert_macros.svh
// assertion macros used by the checker file spq_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define SPQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same, evaluated during reset too
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/spq_pkg.sv
// package for the stable priority queue: defaults, widths, operation codes
// and the command struct passed from the top level to the cells
// no dependencies
`default_nettype none
package spq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int PRIO_BITS_DEF = 8;
  localparam int VALUE_W       = 32;
  localparam int FUNC_W        = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_READ   = 2'd2
  } func_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage
`default_nettype wire

// File: src/spq_cell.sv
// one slot of the sorted chain: holds a value and priority, takes the new
// entry, its left neighbor or its right neighbor; uses spq_pkg
`default_nettype none
module spq_cell #(
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire spq_pkg::cell_cmd_t                 cmd,
  input  wire logic                               valid,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] new_value,
  input  wire logic        [PRIO_BITS-1:0]        new_prio,
  input  wire logic                               left_lt,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] left_value,
  input  wire logic        [PRIO_BITS-1:0]        left_prio,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] right_value,
  input  wire logic        [PRIO_BITS-1:0]        right_prio,
  output logic signed      [spq_pkg::VALUE_W-1:0] value,
  output logic             [PRIO_BITS-1:0]        prio,
  output logic                                    here_lt
);

  // new entry belongs at or before this slot
  assign here_lt = !valid || (prio < new_prio);

  always_ff @(posedge clk) begin
    if (cmd.ins && here_lt) begin
      if (left_lt) begin
        value <= left_value;
        prio  <= left_prio;
      end else begin
        value <= new_value;
        prio  <= new_prio;
      end
    end else if (cmd.rem) begin
      value <= right_value;
      prio  <= right_prio;
    end
  end

endmodule
`default_nettype wire

// File: src/stable_priority_queue.sv
// stable priority queue top level: chain of spq_cell slots, entry count and
// output register; uses spq_pkg and spq_cell
//
//  channel | signals                                         | beat
//  input   | in_valid in_stall func item_value item_priority | one operation
//  output  | out_valid out_stall head_value is_empty          | one result
//          | occupancy dropped                               |
//
// one operation per cycle while in_stall is low: all slots compare and shift in parallel
// result is registered and appears the cycle after the input beat
// reset: count and out_valid clear, slot contents are left as is
// in_stall is high during reset and follows out_stall while a result is
// waiting, so a stall on the output holds the input back with no loss
`default_nettype none
module stable_priority_queue #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [spq_pkg::FUNC_W-1:0]         func,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] item_value,
  input  wire logic [PRIO_BITS-1:0]               item_priority,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [spq_pkg::VALUE_W-1:0]      head_value,
  output logic                                    is_empty,
  output logic [CNT_W-1:0]                        occupancy,
  output logic                                    dropped
);

  logic                               accept;
  logic [CNT_W-1:0]                   count;
  logic [CNT_W-1:0]                   count_next;
  logic                               full;
  logic                               empty;
  spq_pkg::cell_cmd_t                 cmd;
  logic signed [spq_pkg::VALUE_W-1:0] res_value;
  logic                               res_drop;

  logic signed [spq_pkg::VALUE_W-1:0] cell_value [DEPTH];
  logic        [PRIO_BITS-1:0]        cell_prio  [DEPTH];
  logic                               cell_lt    [DEPTH];

  assign in_stall = rst || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    cmd        = '0;
    count_next = count;
    res_drop   = 1'b0;
    res_value  = empty ? '0 : cell_value[0];
    case (spq_pkg::func_t'(func))
      spq_pkg::FUNC_INSERT: begin
        if (full) begin
          res_drop = 1'b1;
        end else begin
          cmd.ins    = accept;
          count_next = count + CNT_W'(1);
          if (cell_lt[0]) begin
            res_value = item_value;
          end
        end
      end
      spq_pkg::FUNC_REMOVE: begin
        if (!empty) begin
          cmd.rem    = accept;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                               left_lt;
      logic signed [spq_pkg::VALUE_W-1:0] left_value;
      logic        [PRIO_BITS-1:0]        left_prio;
      logic signed [spq_pkg::VALUE_W-1:0] right_value;
      logic        [PRIO_BITS-1:0]        right_prio;

      if (i == 0) begin : g_first
        assign left_lt    = 1'b0;
        assign left_value = item_value;
        assign left_prio  = item_priority;
      end else begin : g_mid
        assign left_lt    = cell_lt[i-1];
        assign left_value = cell_value[i-1];
        assign left_prio  = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign right_value = cell_value[i];
        assign right_prio  = cell_prio[i];
      end else begin : g_inner
        assign right_value = cell_value[i+1];
        assign right_prio  = cell_prio[i+1];
      end

      spq_cell #(
        .PRIO_BITS(PRIO_BITS)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .valid      (count > CNT_W'(i)),
        .new_value  (item_value),
        .new_prio   (item_priority),
        .left_lt    (left_lt),
        .left_value (left_value),
        .left_prio  (left_prio),
        .right_value(right_value),
        .right_prio (right_prio),
        .value      (cell_value[i]),
        .prio       (cell_prio[i]),
        .here_lt    (cell_lt[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_value <= res_value;
      is_empty   <= (count_next == '0);
      occupancy  <= count_next;
      dropped    <= res_drop;
    end
  end

endmodule
`default_nettype wire

// File: src/spq_checker.sv
// port-level assertions for stable_priority_queue and the bind that attaches
// them; uses assert_macros.svh and spq_pkg
`default_nettype none
`include "assert_macros.svh"
module spq_checker #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic signed [spq_pkg::VALUE_W-1:0] head_value,
  input wire logic                               is_empty,
  input wire logic [CNT_W-1:0]                   occupancy,
  input wire logic                               dropped
);

  logic out_wait;
  assign out_wait = out_valid && out_stall;

  `SPQ_ASSERT(a_occ_range, clk, rst, out_valid |-> (occupancy <= CNT_W'(DEPTH)), "occupancy high")
  `SPQ_ASSERT(a_empty_flag, clk, rst, out_valid |-> (is_empty == (occupancy == '0)), "empty flag")
  `SPQ_ASSERT(a_drop_full, clk, rst, (out_valid && dropped) |-> (occupancy == CNT_W'(DEPTH)), "drop")
  `SPQ_ASSERT(a_out_hold, clk, rst, out_wait |=> (out_valid && $stable({head_value, occupancy})), "hold")
  `SPQ_ASSERT(a_stall_cause, clk, rst, in_stall |-> out_wait, "input stalled with no waiting beat")

endmodule

bind stable_priority_queue spq_checker #(
  .DEPTH(DEPTH),
  .CNT_W(CNT_W)
) u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .head_value(head_value),
  .is_empty  (is_empty),
  .occupancy (occupancy),
  .dropped   (dropped)
);
`default_nettype wire

// File: tb/sv/tb.sv
// testbench for stable_priority_queue: random and directed insert, remove and read
// beats, checked against a sorted-store predictor held in a small scoreboard class
// depends on spq_pkg and the stable_priority_queue rtl
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = spq_pkg::DEPTH_DEF;
  localparam int PRIO_BITS = spq_pkg::PRIO_BITS_DEF;
  localparam int VALUE_W   = spq_pkg::VALUE_W;
  localparam int FUNC_W    = spq_pkg::FUNC_W;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [VALUE_W-1:0] head;
    logic                      empty;
    logic [CNT_W-1:0]          occ;
    logic                      dropped;
  } queue_result_t;

  class spq_scoreboard;
    logic signed [VALUE_W-1:0] slot_val [DEPTH];
    logic [PRIO_BITS-1:0]      slot_pri [DEPTH];
    int                        count = 0;
    queue_result_t             expected_q [$];
    int                        errors = 0;

    function void note_op(logic [FUNC_W-1:0] f, logic signed [VALUE_W-1:0] v,
                          logic [PRIO_BITS-1:0] p);
      queue_result_t r;
      int pos;
      r = '0;
      if (f == spq_pkg::FUNC_INSERT) begin
        if (count >= DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          pos = 0;
          while (pos < count && slot_pri[pos] >= p) pos++;
          for (int i = count; i > pos; i--) begin
            slot_val[i] = slot_val[i-1];
            slot_pri[i] = slot_pri[i-1];
          end
          slot_val[pos] = v;
          slot_pri[pos] = p;
          count++;
        end
        r.head = (count > 0) ? slot_val[0] : '0;
      end else if (f == spq_pkg::FUNC_REMOVE) begin
        if (count > 0) begin
          r.head = slot_val[0];
          for (int i = 1; i < count; i++) begin
            slot_val[i-1] = slot_val[i];
            slot_pri[i-1] = slot_pri[i];
          end
          count--;
        end
      end else begin
        r.head = (count > 0) ? slot_val[0] : '0;
      end
      r.empty = (count == 0);
      r.occ   = CNT_W'(count);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [VALUE_W-1:0] head, logic empty,
                               logic [CNT_W-1:0] occ, logic dropped);
      queue_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: head %0d occ %0d", head, occ);
        return;
      end
      e = expected_q.pop_front();
      if (head !== e.head || empty !== e.empty || occ !== e.occ || dropped !== e.dropped)
      begin
        errors++;
        if (errors <= 10)
          $display("mismatch at %0t: exp head %0d empty %0b occ %0d dropped %0b,",
                   $realtime, e.head, e.empty, e.occ, e.dropped,
                   " got head %0d empty %0b occ %0d dropped %0b",
                   head, empty, occ, dropped);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [FUNC_W-1:0]         func = spq_pkg::FUNC_READ;
  logic signed [VALUE_W-1:0] item_value = '0;
  logic [PRIO_BITS-1:0]      item_priority = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] head_value;
  logic                      is_empty;
  logic [CNT_W-1:0]          occupancy;
  logic                      dropped;

  spq_scoreboard sb = new;
  int items_in = 0;
  int hold_left = 0;
  bit hold_started = 1'b0;

  stable_priority_queue #(.DEPTH(DEPTH), .PRIO_BITS(PRIO_BITS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .item_value(item_value), .item_priority(item_priority),
    .out_valid(out_valid), .out_stall(out_stall),
    .head_value(head_value), .is_empty(is_empty),
    .occupancy(occupancy), .dropped(dropped)
  );

  always #1 clk = ~clk;

  function automatic bit quiet_window();
    return items_in >= 400 && items_in < 600;
  endfunction

  task automatic send_op(input logic [FUNC_W-1:0] f, input logic signed [VALUE_W-1:0] v,
                         input logic [PRIO_BITS-1:0] p);
    if (!quiet_window()) begin
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    func          <= f;
    item_value    <= v;
    item_priority <= p;
    do @(posedge clk); while (in_stall);
    sb.note_op(f, v, p);
    items_in++;
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PRIO_BITS-1:0] pick_priority();
    int k;
    if ($urandom_range(1)) return PRIO_BITS'($urandom_range(255));
    k = $urandom_range(3);
    return (k == 3) ? 8'd255 : PRIO_BITS'(k);
  endfunction

  // result side: checks each accepted beat and drives out_stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result(head_value, is_empty, occupancy, dropped);
      if (!hold_started && items_in >= 100) begin
        hold_started = 1'b1;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet_window()) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 30);
      end
    end
  end

  initial begin
    int ins_pct;
    int r;
    logic [FUNC_W-1:0] f;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue cases
    send_op(spq_pkg::FUNC_READ, 32'sd5, 8'd1);
    send_op(spq_pkg::FUNC_REMOVE, 32'sd6, 8'd2);
    send_op(FUNC_UNUSED, 32'sd7, 8'd3);
    // fill with extremes and repeated priorities
    send_op(spq_pkg::FUNC_INSERT, 32'sh7fff_ffff, 8'd0);
    send_op(spq_pkg::FUNC_INSERT, 32'sh8000_0000, 8'd255);
    send_op(spq_pkg::FUNC_INSERT, -32'sd1, 8'd255);
    send_op(spq_pkg::FUNC_INSERT, 32'sd0, 8'd0);
    for (int i = 4; i < DEPTH; i++)
      send_op(spq_pkg::FUNC_INSERT, $urandom, (i % 3 == 0) ? 8'd255 : PRIO_BITS'(i % 3));
    // full queue
    send_op(spq_pkg::FUNC_INSERT, 32'sh1234_5678, 8'd255);
    send_op(FUNC_UNUSED, 32'sd0, 8'd0);
    send_op(spq_pkg::FUNC_REMOVE, 32'sd0, 8'd0);

    ins_pct = 50;
    for (int n = 0; n < 1000; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(2))
          0: ins_pct = 15;
          1: ins_pct = 50;
          default: ins_pct = 85;
        endcase
      end
      if ($urandom_range(99) < ins_pct) begin
        f = spq_pkg::FUNC_INSERT;
      end else begin
        r = $urandom_range(9);
        f = (r < 7) ? spq_pkg::FUNC_REMOVE : (r < 9) ? spq_pkg::FUNC_READ : FUNC_UNUSED;
      end
      send_op(f, pick_value(), pick_priority());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
